// File: sv/gcmb_pkg.sv
`timescale 1ns / 1ps
package gcmb_pkg;
	localparam int REG_AXIS_A = 0;
	localparam int REG_AXIS_B = 1;
	localparam int REG_MIN_A = 2;
	localparam int REG_MIN_B = 3;
	localparam int REG_EXT_A = 4;
	localparam int REG_EXT_B = 5;
	localparam int REG_SIDE = 6;
	localparam int REG_PRIM = 7;
	localparam logic signed [31:0] EXTENT_FLOOR = 32'sd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_A,
		ST_DIV_B,
		ST_SEARCH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctl_t;
endpackage

// File: sv/gcmb_cell_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: floor(d*side/ext), clamped.
module gcmb_cell_div import gcmb_pkg::*; #(
	parameter int SIDE_W = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [32:0]       d,
	input  logic signed [31:0]       ext,
	input  logic [SIDE_W-1:0]        side,
	output div_ctl_t                 ctl,
	output logic [SIDE_W-1:0]        quo_sat
);
	localparam int NUM_W = 33 + SIDE_W;
	localparam int CNT_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] quo_q;
	logic [32:0]      rem_q;
	logic [31:0]      den_q;
	logic [SIDE_W-1:0] lim_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [33:0]      trial;
	logic [NUM_W-1:0] prod;

	assign prod = NUM_W'(d[31:0]) * NUM_W'(side);
	assign trial = {rem_q, num_q[NUM_W-1]} - {2'b00, den_q};

	// Shift one bit of the product through the remainder per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= (d <= 0 || side <= SIDE_W'(1) || ext <= EXTENT_FLOOR) ? '0 : prod;
			den_q <= (ext <= EXTENT_FLOOR) ? 32'd1 : ext;
			lim_q <= (side == '0) ? '0 : side - 1'b1;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			if (!trial[33]) begin
				rem_q <= trial[32:0];
				quo_q <= {quo_q[NUM_W-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[31:0], num_q[NUM_W-1]};
				quo_q <= {quo_q[NUM_W-2:0], 1'b0};
			end
		end
	end

	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign ctl.done = done_q;
	assign quo_sat = (quo_q > NUM_W'(lim_q)) ? lim_q : quo_q[SIDE_W-1:0];

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without busy");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !done_q) else $error("done while busy");
	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0) else $error("busy with zero count");
endmodule

// File: sv/grid_cell_material_binning_core.sv
`timescale 1ns / 1ps
// Grid cell material binning core.
// Input stream s_axis_*: tdata holds center_x, center_y, center_z, prim_index,
// material (lowest first); tuser holds first. One word at a time is taken:
// s_axis_tready is high only while the block is idle.
// Per item the shared serial divider runs twice (one quotient bit per cycle),
// then the key memory is scanned one slot per cycle up to the current count,
// one read port. The scan stops early on a match. A skipped item bypasses
// the divider and the scan and goes straight to the output register.
// Output stream m_axis_*: tdata holds cell_a, cell_b, target_index,
// new_target, distinct_count, skipped, table_full. The result is held in an
// output register until taken; a stalled receiver stalls the block.
// Reset clears configuration to defaults and the distinct count to zero; the
// key memory needs no clearing since only slots below the count are read.
// Configuration goes through the APB port, registers at 4*i.
module grid_cell_material_binning_core import gcmb_pkg::*; #(
	parameter int MAX_TARGETS = 1024,
	parameter int MAX_SIDE = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// center_x[31:0], center_y[63:32], center_z[95:64], prim_index[111:96],
	// material[123:112], zero pad
	input  logic [127:0] s_axis_tdata,
	// first[0]
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// cell_a[5:0], cell_b[11:6], target_index[21:12], new_target[22],
	// distinct_count[33:23], skipped[34], table_full[35], zero pad
	output logic [39:0]  m_axis_tdata
);
	localparam int IDX_W = $clog2(MAX_TARGETS);
	localparam int CNT_W = $clog2(MAX_TARGETS + 1);
	localparam int SIDE_W = $clog2(MAX_SIDE + 1);

	logic [1:0]         axis_a_q, axis_b_q;
	logic signed [31:0] min_a_q, min_b_q, ext_a_q, ext_b_q;
	logic [6:0]         side_q;
	logic [16:0]        prim_cnt_q;
	logic               wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// Register file writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_a_q <= 2'd0;
			axis_b_q <= 2'd2;
			min_a_q <= '0;
			min_b_q <= '0;
			ext_a_q <= '0;
			ext_b_q <= '0;
			side_q <= 7'd1;
			prim_cnt_q <= '0;
		end else if (wr) begin
			case (paddr[4:2])
				3'(REG_AXIS_A): axis_a_q <= pwdata[1:0];
				3'(REG_AXIS_B): axis_b_q <= pwdata[1:0];
				3'(REG_MIN_A): min_a_q <= pwdata;
				3'(REG_MIN_B): min_b_q <= pwdata;
				3'(REG_EXT_A): ext_a_q <= pwdata;
				3'(REG_EXT_B): ext_b_q <= pwdata;
				3'(REG_SIDE): side_q <= pwdata[6:0];
				3'(REG_PRIM): prim_cnt_q <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			3'(REG_AXIS_A): prdata = {30'd0, axis_a_q};
			3'(REG_AXIS_B): prdata = {30'd0, axis_b_q};
			3'(REG_MIN_A): prdata = min_a_q;
			3'(REG_MIN_B): prdata = min_b_q;
			3'(REG_EXT_A): prdata = ext_a_q;
			3'(REG_EXT_B): prdata = ext_b_q;
			3'(REG_SIDE): prdata = {25'd0, side_q};
			3'(REG_PRIM): prdata = {15'd0, prim_cnt_q};
			default: prdata = '0;
		endcase
	end

	// Item registers
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [11:0]        mat_q;
	logic [SIDE_W-1:0]  ca_q, cb_q, side_sat;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   scan_q, slot_q;
	logic               new_q, skip_q, full_q;
	logic [23:0]        key_mem [MAX_TARGETS];
	logic [23:0]        rd_q;
	logic               rd_ok_s1;
	logic [IDX_W-1:0]   rd_idx_s1;
	state_t             state_q, state_d;

	assign side_sat = ({25'd0, side_q} > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
		: SIDE_W'(side_q);

	function automatic logic signed [31:0] pick(input logic [1:0] ax,
		input logic signed [31:0] x, input logic signed [31:0] y,
		input logic signed [31:0] z);
		case (ax)
			2'd0: pick = x;
			2'd1: pick = y;
			default: pick = z;
		endcase
	endfunction

	logic              div_start;
	logic signed [32:0] div_d;
	logic signed [31:0] div_ext;
	div_ctl_t          div_ctl;
	logic [SIDE_W-1:0] div_cell;

	assign div_d = (state_q == ST_IDLE)
		? 33'(pick(axis_a_q, cx_q, cy_q, cz_q)) - 33'(min_a_q)
		: 33'(pick(axis_b_q, cx_q, cy_q, cz_q)) - 33'(min_b_q);
	assign div_ext = (state_q == ST_IDLE) ? ext_a_q : ext_b_q;

	gcmb_cell_div #(.SIDE_W(SIDE_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .d(div_d), .ext(div_ext),
		.side(side_sat), .ctl(div_ctl), .quo_sat(div_cell)
	);

	logic        go_q;
	logic [23:0] key;
	logic        acc;
	assign key = {mat_q, 6'(ca_q), 6'(cb_q)};
	assign acc = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE) && !go_q;

	// Next state and divider kicks
	always_comb begin
		state_d = state_q;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: if (go_q) begin
				if (skip_q) state_d = ST_OUT;
				else begin
					div_start = 1'b1;
					state_d = ST_DIV_A;
				end
			end
			ST_DIV_A: if (div_ctl.done) begin
				div_start = 1'b1;
				state_d = ST_DIV_B;
			end
			ST_DIV_B: if (div_ctl.done) state_d = ST_SEARCH;
			ST_SEARCH: if (rd_ok_s1 && rd_q == key) state_d = ST_OUT;
				else if (!rd_ok_s1 && CNT_W'(scan_q) >= count_q) state_d = ST_OUT;
				else if (rd_ok_s1 && CNT_W'(rd_idx_s1) + 1'b1 >= count_q) state_d = ST_OUT;
			ST_OUT: if (m_axis_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	logic hit, end_scan;
	assign hit = (state_q == ST_SEARCH) && rd_ok_s1 && rd_q == key;
	assign end_scan = (state_q == ST_SEARCH) && !hit && (state_d == ST_OUT);

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			go_q <= 1'b0;
			count_q <= '0;
			rd_ok_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			go_q <= acc;
			if (acc && s_axis_tuser) count_q <= '0;
			rd_ok_s1 <= (state_q == ST_SEARCH) && state_d == ST_SEARCH
				&& CNT_W'(scan_q) < count_q;
			if (end_scan && count_q < CNT_W'(MAX_TARGETS)) count_q <= count_q + 1'b1;
		end
	end

	// Datapath, memory scan and result capture
	always_ff @(posedge clk) begin
		if (acc) begin
			cx_q <= s_axis_tdata[31:0];
			cy_q <= s_axis_tdata[63:32];
			cz_q <= s_axis_tdata[95:64];
			mat_q <= s_axis_tdata[123:112];
			skip_q <= {1'b0, s_axis_tdata[111:96]} >= prim_cnt_q;
			ca_q <= '0;
			cb_q <= '0;
			slot_q <= '0;
			new_q <= 1'b0;
			full_q <= 1'b0;
			scan_q <= '0;
		end
		if (state_q == ST_DIV_A && div_ctl.done) ca_q <= div_cell;
		if (state_q == ST_DIV_B && div_ctl.done) cb_q <= div_cell;
		if (state_q == ST_SEARCH && state_d == ST_SEARCH && CNT_W'(scan_q) < count_q) begin
			rd_q <= key_mem[scan_q];
			rd_idx_s1 <= scan_q;
			scan_q <= scan_q + 1'b1;
		end
		if (hit) slot_q <= rd_idx_s1;
		if (end_scan) begin
			if (count_q < CNT_W'(MAX_TARGETS)) begin
				key_mem[count_q[IDX_W-1:0]] <= key;
				slot_q <= count_q[IDX_W-1:0];
				new_q <= 1'b1;
			end else full_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = (state_q == ST_OUT);
	assign m_axis_tdata = {4'd0, full_q, skip_q, 11'(count_q), new_q,
		10'(slot_q), 6'(cb_q), 6'(ca_q)};

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_TARGETS)) else $error("count overflow");
	a_new_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(new_q && full_q)) else $error("new and full");
	a_skip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && skip_q) |-> !new_q) else $error("skipped item inserted");
endmodule

// File: sim/grid_cell_material_binning_core_test.sv
`timescale 1ns / 1ps
module grid_cell_material_binning_core_test;
	import gcmb_pkg::*;

	localparam int  TABLE_DEPTH = 1024;
	localparam int  SIDE_CAP = 64;
	localparam int  HOLD_CYCLES = 600;
	localparam int  SETTLE_CYCLES = 1200;
	localparam longint CYCLE_LIMIT = 20000000;

	typedef struct {
		logic [1:0]         axis_a;
		logic [1:0]         axis_b;
		logic signed [31:0] min_a;
		logic signed [31:0] min_b;
		logic signed [31:0] ext_a;
		logic signed [31:0] ext_b;
		logic [6:0]         side;
		logic [16:0]        pcount;
	} grid_cfg_t;

	typedef struct {
		logic               first;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
		logic [15:0]        prim;
		logic [11:0]        mat;
	} instance_t;

	typedef struct {
		logic [5:0]  cell_a;
		logic [5:0]  cell_b;
		logic [9:0]  target;
		logic        is_new;
		logic [10:0] count;
		logic        skipped;
		logic        full;
	} binning_t;

	typedef struct {
		grid_cfg_t cfg;
		instance_t inst;
		bit        has_exp;
		binning_t  exp;
	} vector_t;

	logic         clk;
	logic         arst_n;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [4:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	// center_x, center_y, center_z, prim_index, material, zero pad
	logic [127:0] s_axis_tdata;
	// first
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	// cell_a, cell_b, target_index, new_target, distinct_count, skipped,
	// table_full, zero pad
	logic [39:0]  m_axis_tdata;

	grid_cfg_t    cfg_shadow;
	logic [23:0]  key_store [TABLE_DEPTH];
	int           key_total;
	binning_t     bin_q [$];
	vector_t      vectors [$];
	int           mismatches;
	longint       cycles;
	bit           hold_req;

	grid_cell_material_binning_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("grid_cell_material_binning_core test failed");
			$finish;
		end
	end

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	function automatic logic signed [31:0] pick_axis(logic [1:0] axis, instance_t it);
		if (axis == 2'd0)
			return it.cx;
		if (axis == 2'd1)
			return it.cy;
		return it.cz;
	endfunction

	// Floor of (v-min)*side/extent, clamped to the grid
	function automatic logic [5:0] grid_cell(longint v, longint mn, longint ext,
			logic [6:0] side_reg);
		longint side;
		longint d;
		longint q;
		side = longint'(side_reg);
		if (side > SIDE_CAP)
			side = SIDE_CAP;
		if (side <= 1 || ext <= EXTENT_FLOOR)
			return 6'd0;
		d = v - mn;
		if (d <= 0)
			return 6'd0;
		q = (d * side) / ext;
		if (q > side - 1)
			q = side - 1;
		return q[5:0];
	endfunction

	// Bin one instance and update the key store
	function automatic binning_t bin_instance(instance_t it);
		binning_t r;
		logic [23:0] key;
		int i;
		r = '{default: '0};
		if (it.first)
			key_total = 0;
		r.skipped = ({1'b0, it.prim} >= cfg_shadow.pcount);
		if (!r.skipped) begin
			r.cell_a = grid_cell(longint'(pick_axis(cfg_shadow.axis_a, it)),
				longint'(cfg_shadow.min_a), longint'(cfg_shadow.ext_a), cfg_shadow.side);
			r.cell_b = grid_cell(longint'(pick_axis(cfg_shadow.axis_b, it)),
				longint'(cfg_shadow.min_b), longint'(cfg_shadow.ext_b), cfg_shadow.side);
			key = {it.mat, r.cell_a, r.cell_b};
			for (i = 0; i < key_total; i++)
				if (key_store[i] == key)
					break;
			if (i < key_total) begin
				r.target = i[9:0];
			end else if (key_total < TABLE_DEPTH) begin
				key_store[key_total] = key;
				r.target = key_total[9:0];
				key_total++;
				r.is_new = 1'b1;
			end else begin
				r.full = 1'b1;
			end
		end
		r.count = key_total[10:0];
		return r;
	endfunction

	task automatic apb_write(int idx, logic [31:0] val);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 5'(idx * 4);
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// Drain the block, then write every register that changes
	task automatic program_grid(grid_cfg_t c);
		s_axis_tvalid <= 1'b0;
		while (bin_q.size() != 0)
			@(negedge clk);
		if (c.axis_a != cfg_shadow.axis_a) apb_write(REG_AXIS_A, 32'(c.axis_a));
		if (c.axis_b != cfg_shadow.axis_b) apb_write(REG_AXIS_B, 32'(c.axis_b));
		if (c.min_a != cfg_shadow.min_a) apb_write(REG_MIN_A, c.min_a);
		if (c.min_b != cfg_shadow.min_b) apb_write(REG_MIN_B, c.min_b);
		if (c.ext_a != cfg_shadow.ext_a) apb_write(REG_EXT_A, c.ext_a);
		if (c.ext_b != cfg_shadow.ext_b) apb_write(REG_EXT_B, c.ext_b);
		if (c.side != cfg_shadow.side) apb_write(REG_SIDE, 32'(c.side));
		if (c.pcount != cfg_shadow.pcount) apb_write(REG_PRIM, 32'(c.pcount));
		cfg_shadow = c;
	endtask

	// Offer one word after a random gap; called and returns at a falling edge
	task automatic send_instance(instance_t it, bit has_exp, binning_t exp);
		int gap;
		binning_t r;
		gap = $urandom_range(0, 8);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata <= {4'b0, it.mat, it.prim, it.cz, it.cy, it.cx};
		s_axis_tuser <= it.first;
		s_axis_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		r = bin_instance(it);
		if (has_exp && r != exp)
			report_mismatch("directed row disagrees with predictor", 0, 1);
		bin_q = {bin_q, (has_exp ? exp : r)};
		@(negedge clk);
	endtask

	// Receiver: random stalls, one long hold on request
	initial begin
		int wait_cycles;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			wait_cycles = $urandom_range(0, 8);
			if (wait_cycles > 0) begin
				m_axis_tready <= 1'b0;
				repeat (wait_cycles) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	// Compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		binning_t want;
		binning_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.cell_a = m_axis_tdata[5:0];
			got.cell_b = m_axis_tdata[11:6];
			got.target = m_axis_tdata[21:12];
			got.is_new = m_axis_tdata[22];
			got.count = m_axis_tdata[33:23];
			got.skipped = m_axis_tdata[34];
			got.full = m_axis_tdata[35];
			if (bin_q.size() == 0) begin
				report_mismatch("word with nothing expected", m_axis_tdata, 0);
			end else begin
				want = bin_q.pop_front();
				if (got.cell_a != want.cell_a) report_mismatch("cell_a", got.cell_a, want.cell_a);
				if (got.cell_b != want.cell_b) report_mismatch("cell_b", got.cell_b, want.cell_b);
				if (got.target != want.target)
					report_mismatch("target_index", got.target, want.target);
				if (got.is_new != want.is_new)
					report_mismatch("new_target", got.is_new, want.is_new);
				if (got.count != want.count)
					report_mismatch("distinct_count", got.count, want.count);
				if (got.skipped != want.skipped)
					report_mismatch("skipped", got.skipped, want.skipped);
				if (got.full != want.full) report_mismatch("table_full", got.full, want.full);
			end
		end
	end

	function automatic logic signed [31:0] rand_coord(longint mn, longint ext);
		longint e;
		longint v;
		case ($urandom_range(0, 7))
			0: return $urandom;
			1: return mn[31:0];
			2: begin
				v = mn + ext;
				return v[31:0];
			end
			default: begin
				e = (ext > 0) ? ext : 64'h10000;
				v = mn - e / 8 + (longint'($urandom) % (e + e / 4 + 1));
				return v[31:0];
			end
		endcase
	endfunction

	function automatic logic signed [31:0] rand_extent();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 7);
			1: return -$signed(32'($urandom_range(1, 1000)));
			2: return $urandom;
			3: return 32'h7fffffff;
			default: return $urandom_range(7, 32'h0040_0000);
		endcase
	endfunction

	function automatic grid_cfg_t rand_grid();
		grid_cfg_t c;
		c.axis_a = 2'($urandom_range(0, 3));
		c.axis_b = 2'($urandom_range(0, 3));
		c.min_a = ($urandom_range(0, 5) == 0) ? $urandom : $signed(32'($urandom_range(0, 32'h20_0000))) - 32'sh10_0000;
		c.min_b = ($urandom_range(0, 5) == 0) ? $urandom : $signed(32'($urandom_range(0, 32'h20_0000))) - 32'sh10_0000;
		c.ext_a = rand_extent();
		c.ext_b = rand_extent();
		case ($urandom_range(0, 7))
			0: c.side = 7'($urandom_range(0, 127));
			1: c.side = 7'd64;
			default: c.side = 7'($urandom_range(1, 16));
		endcase
		c.pcount = ($urandom_range(0, 2) == 0) ? 17'($urandom_range(0, 65536)) : 17'd65536;
		return c;
	endfunction

	function automatic instance_t rand_instance(bit first, grid_cfg_t c);
		instance_t it;
		longint mx;
		longint my;
		it.first = first;
		// Put the projected axes near the scene box, the third one anywhere
		it.cx = $urandom;
		it.cy = $urandom;
		it.cz = $urandom;
		if (c.axis_a == 2'd0) it.cx = rand_coord(longint'(c.min_a), longint'(c.ext_a));
		else if (c.axis_a == 2'd1) it.cy = rand_coord(longint'(c.min_a), longint'(c.ext_a));
		else it.cz = rand_coord(longint'(c.min_a), longint'(c.ext_a));
		if (c.axis_b == 2'd0) it.cx = rand_coord(longint'(c.min_b), longint'(c.ext_b));
		else if (c.axis_b == 2'd1) it.cy = rand_coord(longint'(c.min_b), longint'(c.ext_b));
		else it.cz = rand_coord(longint'(c.min_b), longint'(c.ext_b));
		mx = longint'(c.pcount);
		if ($urandom_range(0, 4) == 0 || mx == 0)
			it.prim = 16'($urandom);
		else
			it.prim = 16'($urandom_range(0, 32'(mx - 1)));
		it.mat = ($urandom_range(0, 5) == 0) ? 12'($urandom) : 12'($urandom_range(0, 7));
		return it;
	endfunction

	task automatic add_vector(grid_cfg_t c, instance_t it, bit has_exp, binning_t exp);
		vector_t v;
		v.cfg = c;
		v.inst = it;
		v.has_exp = has_exp;
		v.exp = exp;
		vectors = {vectors, v};
	endtask

	initial begin
		grid_cfg_t rst_cfg;
		grid_cfg_t c;
		grid_cfg_t wide;
		instance_t it;
		binning_t none;
		binning_t skip_exp;
		int n;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		mismatches = 0;
		cycles = 0;
		hold_req = 1'b0;
		key_total = 0;
		rst_cfg = '{axis_a: 2'd0, axis_b: 2'd2, min_a: 0, min_b: 0, ext_a: 0, ext_b: 0,
			side: 7'd1, pcount: 17'd0};
		cfg_shadow = rst_cfg;
		none = '{default: '0};
		skip_exp = none;
		skip_exp.skipped = 1'b1;

		// Directed vectors
		it = '{first: 1'b1, cx: 32'h7fffffff, cy: 32'h80000000, cz: 32'h12345678,
			prim: 16'hffff, mat: 12'hfff};
		add_vector(rst_cfg, it, 1, skip_exp);
		it.prim = 16'h0;
		add_vector(rst_cfg, it, 1, skip_exp);
		wide = '{axis_a: 2'd0, axis_b: 2'd1, min_a: -32'sh10000, min_b: -32'sh10000,
			ext_a: 32'sh20000, ext_b: 32'sh20000, side: 7'd64, pcount: 17'd65536};
		it = '{first: 1'b1, cx: -32'sh10000, cy: 32'h7fffffff, cz: 0, prim: 16'hffff,
			mat: 12'hfff};
		add_vector(wide, it, 0, none);
		add_vector(wide, it, 0, none);
		it.first = 1'b0; it.cx = 32'h80000000; it.cy = 32'h80000000; it.mat = 12'h0;
		add_vector(wide, it, 0, none);
		it.cx = 32'sh10000; it.cy = 32'sh0ffff;
		add_vector(wide, it, 0, none);
		it.cx = 32'sh0ffff; it.cy = 32'sh10000;
		add_vector(wide, it, 0, none);
		// Primitive count boundary
		c = wide; c.pcount = 17'd10;
		it.prim = 16'd9;
		add_vector(c, it, 0, none);
		it.prim = 16'd10;
		add_vector(c, it, 0, none);
		// Skipped item still clears the table
		it.first = 1'b1;
		add_vector(c, it, 0, none);
		it.first = 1'b0; it.prim = 16'd0;
		add_vector(c, it, 0, none);
		// Side zero and side above the cap
		c = wide; c.side = 7'd0;
		add_vector(c, it, 0, none);
		c.side = 7'd127;
		it.cx = 32'sh7000; it.cy = 32'sh7fffffff;
		add_vector(c, it, 0, none);
		// Axis code three and the extent floor
		c = wide; c.axis_a = 2'd3; c.axis_b = 2'd2; c.ext_a = 32'sd6; c.ext_b = 32'sd7;
		c.min_a = 0; c.min_b = 0;
		it.cz = 32'sd5;
		add_vector(c, it, 0, none);
		it.cz = 32'sd3;
		add_vector(c, it, 0, none);
		c.ext_a = -32'sd1; c.ext_b = 32'h80000000;
		add_vector(c, it, 0, none);
		c = wide; c.axis_a = 2'd2; c.axis_b = 2'd0; c.side = 7'd2;
		it.cx = 32'sh0; it.cz = -32'sh1;
		add_vector(c, it, 0, none);

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (vectors[i]) begin
			if (vectors[i].cfg != cfg_shadow)
				program_grid(vectors[i].cfg);
			send_instance(vectors[i].inst, vectors[i].has_exp, vectors[i].exp);
		end

		// Random phases with small tables
		for (int ph = 0; ph < 14; ph++) begin
			c = rand_grid();
			if (ph == 0) c.pcount = 17'd65536;
			program_grid(c);
			if (ph == 3)
				hold_req = 1'b1;
			for (int k = 0; k < 40; k++) begin
				it = rand_instance(k == 0 || $urandom_range(0, 29) == 0, c);
				send_instance(it, 0, none);
			end
		end

		// Fill the key store to the brim and beyond
		c = rand_grid();
		c.side = 7'd1;
		c.pcount = 17'd65536;
		program_grid(c);
		for (int k = 0; k < 1040; k++) begin
			it = rand_instance(k == 0, c);
			it.prim = 16'($urandom_range(0, 65535));
			n = (k % 50 == 49) ? 0 : k;
			it.mat = 12'(n);
			send_instance(it, 0, none);
		end
		for (int k = 0; k < 8; k++) begin
			it = rand_instance(0, c);
			it.mat = (k < 6) ? 12'(3000 + k) : 12'(k);
			send_instance(it, 0, none);
		end

		// A few more random phases after the fill
		for (int ph = 0; ph < 4; ph++) begin
			c = rand_grid();
			program_grid(c);
			for (int k = 0; k < 40; k++) begin
				it = rand_instance(k == 0 || $urandom_range(0, 29) == 0, c);
				send_instance(it, 0, none);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (bin_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("grid_cell_material_binning_core test passed");
		end else begin
			$display("grid_cell_material_binning_core test failed");
		end
		$finish;
	end
endmodule

// File: files.f
sv/gcmb_pkg.sv
sv/gcmb_cell_div.sv
sv/grid_cell_material_binning_core.sv
sim/grid_cell_material_binning_core_test.sv
